// ----- sv/b64d_pkg.sv -----
// Shared types, constants and the alphabet lookup function for the base64 stream decoder.
// No dependencies.
package b64d_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned SextetW = 6;
  localparam int unsigned AccW    = 12;
  localparam int unsigned PendW   = 4;
  localparam int unsigned CountW  = 13;
  localparam int unsigned InDataW = 8;
  localparam int unsigned OutDataW = 24;

  localparam logic [CharW-1:0]  ChNul     = 8'd0;
  localparam logic [CharW-1:0]  ChNewline = 8'd10;
  localparam logic [CountW-1:0] MaxOutput = 13'd4096;
  localparam logic [CountW-1:0] MaxBytesReset = 13'd4096;
  localparam logic [PendW-1:0]  ByteBits  = 4'd8;

  // Classified character.
  typedef struct packed {
    logic               is_term;
    logic               is_sym;
    logic [SextetW-1:0] sextet;
  } sym_t;

  // One result as it leaves the core.
  typedef struct packed {
    logic              vld;
    logic              last;
    logic [7:0]        data;
    logic [CountW-1:0] count;
  } res_t;

  function automatic sym_t classify(input logic [CharW-1:0] c);
    sym_t s;
    s.is_term = (c == ChNul) || (c == ChNewline);
    s.is_sym  = 1'b1;
    s.sextet  = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.sextet = SextetW'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.sextet = SextetW'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.sextet = SextetW'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      s.sextet = 6'd62;
    end else if (c == 8'h2F) begin
      s.sextet = 6'd63;
    end else begin
      s.is_sym = 1'b0;
    end
    return s;
  endfunction

endpackage

// ----- sv/b64d_lookup.sv -----
// Character classifier: terminator detection and base64 alphabet lookup.
// Depends on b64d_pkg.
module b64d_lookup (
  input  logic [b64d_pkg::CharW-1:0] char_i,
  output b64d_pkg::sym_t             sym_o
);
  import b64d_pkg::*;

  always_comb begin
    sym_o = classify(char_i);
  end

endmodule

// ----- sv/b64d_core.sv -----
// Decoder state (bit accumulator, pending bits, byte count) and per-character result.
// Depends on b64d_pkg.
module b64d_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        take_i,
  input  b64d_pkg::sym_t              sym_i,
  input  logic [b64d_pkg::CountW-1:0] max_bytes_i,
  output b64d_pkg::res_t              res_o
);
  import b64d_pkg::*;

  logic [AccW-1:0]   acc_q, acc_d;
  logic [PendW-1:0]  pend_q, pend_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [CountW-1:0] limit;
  logic [AccW-1:0]   acc_sh;
  logic [PendW-1:0]  pend_sum;
  logic [PendW-1:0]  pend_left;
  logic [AccW-1:0]   byte_sh;

  assign limit     = (max_bytes_i > MaxOutput) ? MaxOutput : max_bytes_i;
  assign acc_sh    = {acc_q[AccW-SextetW-1:0], sym_i.sextet};
  assign pend_sum  = pend_q + PendW'(SextetW);
  assign pend_left = pend_sum - ByteBits;
  assign byte_sh   = acc_sh >> pend_left;

  always_comb begin
    acc_d  = acc_q;
    pend_d = pend_q;
    cnt_d  = cnt_q;
    res_o  = '0;
    if (sym_i.is_term) begin
      // end marker carries the count; drop trailing bits
      res_o.vld   = 1'b1;
      res_o.last  = 1'b1;
      res_o.count = cnt_q;
      acc_d  = '0;
      pend_d = '0;
      cnt_d  = '0;
    end else if (sym_i.is_sym && (cnt_q < limit)) begin
      acc_d = acc_sh;
      if (pend_sum < ByteBits) begin
        pend_d = pend_sum;
      end else begin
        pend_d      = pend_left;
        cnt_d       = cnt_q + 1'b1;
        res_o.vld   = 1'b1;
        res_o.data  = byte_sh[7:0];
        res_o.count = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      pend_q <= '0;
      cnt_q  <= '0;
    end else if (take_i) begin
      acc_q  <= acc_d;
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ----- sv/base64_stream_decoder.sv -----
// Top level of the base64 stream decoder: input register, core, result register, config.
// Depends on b64d_pkg, b64d_lookup and b64d_core.
//
//  port group  | dir | payload
//  s_axis      | in  | tdata[7:0] char_in
//  m_axis      | out | tdata[7:0] out_byte, [20:8] byte_count; tlast is_end
//  cfg         | in  | cfg_wdata_i[12:0] max_bytes (limit saturates at 4096)
//
// One character per cycle while the output is not stalled: a beat sits in the
// input register, is decoded and folded into the state, and its result lands in the
// output register.
// A stalled output holds the result register and then the input register.
// Reset clears the decoder state and sets max_bytes to 4096.
module base64_stream_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [b64d_pkg::InDataW-1:0]  s_axis_tdata_i,  // [7:0] char_in
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [b64d_pkg::OutDataW-1:0] m_axis_tdata_o,  // [7:0] out_byte, [20:8] byte_count
  output logic                          m_axis_tlast_o,  // is_end
  input  logic                          cfg_we_i,
  input  logic [b64d_pkg::CountW-1:0]   cfg_wdata_i      // max_bytes
);
  import b64d_pkg::*;

  logic              in_vld_q;
  logic [CharW-1:0]  in_char_q;
  logic              out_vld_q;
  logic              out_last_q;
  logic [7:0]        out_byte_q;
  logic [CountW-1:0] out_cnt_q;
  logic [CountW-1:0] max_bytes_q;
  logic              out_free;
  logic              take;
  sym_t              sym;
  res_t              res;

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign take            = in_vld_q && out_free;
  assign s_axis_tready_o = !in_vld_q || out_free;

  b64d_lookup u_lookup (
    .char_i (in_char_q),
    .sym_o  (sym)
  );

  b64d_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .sym_i       (sym),
    .max_bytes_i (max_bytes_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      max_bytes_q <= MaxBytesReset;
    end else begin
      if (cfg_we_i) begin
        max_bytes_q <= cfg_wdata_i;
      end
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (out_free) begin
        out_vld_q <= take && res.vld;
      end
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_char_q <= s_axis_tdata_i[CharW-1:0];
    end
    if (take && res.vld) begin
      out_last_q <= res.last;
      out_byte_q <= res.data;
      out_cnt_q  <= res.count;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {(OutDataW - CountW - 8)'(0), out_cnt_q, out_byte_q};

endmodule
